// File: hw/rtl/npt_pkg.sv
// shared constants and types of the nat port table
`default_nettype none
package npt_pkg;
   localparam int PORT_SLOTS = 4096;
   localparam int SLOT_W     = $clog2(PORT_SLOTS);

   localparam logic [2:0] REQ_ALLOC = 3'd0;
   localparam logic [2:0] REQ_FIND  = 3'd1;
   localparam logic [2:0] REQ_MAP   = 3'd2;
   localparam logic [2:0] REQ_FREE  = 3'd3;
   localparam logic [2:0] REQ_CLEAR = 3'd4;

   localparam logic CSR_FIRST_PORT = 1'b0;
   localparam logic CSR_TIMEOUT    = 1'b1;

   localparam logic [15:0] FIRST_PORT_RESET = 16'd10000;
   localparam logic [31:0] TIMEOUT_RESET    = 32'd60;

   typedef struct packed {
      logic        valid;
      logic [31:0] sip;
      logic [15:0] sport;
      logic [31:0] dip;
      logic [15:0] dport;
      logic [31:0] stamp;
      logic [31:0] order;
   } entry_type;
endpackage
`default_nettype wire

// File: hw/rtl/nat_port_table_top.sv
// nat port translation table with one entry memory and a scanning sequencer
//
// channel  dir  tdata                                           tuser
// req      in   src_ip src_port dst_ip dst_port nat_port now   req_type
// rsp      out  nat_port src_ip src_port dst_ip dst_port       hit
// csr      in   index 0 first_port, index 1 timeout_seconds
//
// allocate scans from slot 0 and stops at the first usable slot; find scans every slot,
// both by one entry read per cycle from the slot memory
// map reads one slot, free and unknown codes are answered from idle, clear all writes every slot
// after reset a clearing pass over all PORT_SLOTS slots runs before the first request
// one request at a time; a new request waits until the response is taken
`default_nettype none
module nat_port_table_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // src_ip, src_port, dst_ip, dst_port, nat_port, now_seconds
   input  wire logic [143:0] req_tdata,
   // req_type
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_nat_port, out_src_ip, out_src_port, out_dst_ip, out_dst_port
   output logic [111:0]      rsp_tdata,
   // hit
   output logic              rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic         csr_addr,
   input  wire logic [31:0]  csr_wdata
);
   import npt_pkg::*;

   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_MAP  = 3'd3;
   localparam logic [2:0] S_FWR  = 3'd4;
   localparam logic [2:0] S_CLR  = 3'd5;

   entry_type mem [PORT_SLOTS];
   entry_type rd_ff;
   logic             mem_we;
   logic [SLOT_W-1:0] mem_wa, mem_ra;
   entry_type        mem_wd;

   logic [2:0]  state_ff, state_in;
   logic [SLOT_W:0] cnt_ff, cnt_in;
   logic [SLOT_W-1:0] chk_ff, chk_in;
   logic        pend_ff, pend_in;
   logic [15:0] first_port_ff;
   logic [31:0] timeout_ff;
   logic [31:0] alloc_cnt_ff, alloc_cnt_in;
   logic [2:0]  op_ff, op_in;
   logic [143:0] req_ff, req_in;
   logic        found_ff, found_in;
   logic [SLOT_W-1:0] best_ff, best_in;
   logic [31:0] best_age_ff, best_age_in;
   logic [31:0] best_order_ff, best_order_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_hit_ff, rsp_hit_in;
   logic [111:0] rsp_data_ff, rsp_data_in;

   logic [31:0] q_sip, q_dip, q_now;
   logic [15:0] q_sport, q_dport, p_nport, map_idx, free_idx;
   logic        accept, in_lim, usable, match, last, map_ok, free_ok;
   logic [31:0] age;
   logic [16:0] port_sum;

   assign q_sip   = req_ff[31:0];
   assign q_sport = req_ff[47:32];
   assign q_dip   = req_ff[79:48];
   assign q_dport = req_ff[95:80];
   assign q_now   = req_ff[143:112];
   assign p_nport = req_tdata[111:96];

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign port_sum = {1'b0, first_port_ff} + 17'(chk_ff);
   assign in_lim   = port_sum <= 17'h0FFFF;
   assign usable   = !rd_ff.valid || ((q_now - rd_ff.stamp) > timeout_ff);
   assign match    = rd_ff.valid && rd_ff.sip == q_sip && rd_ff.sport == q_sport &&
                     rd_ff.dip == q_dip && rd_ff.dport == q_dport;
   assign age      = alloc_cnt_ff - rd_ff.order;
   assign last     = chk_ff == SLOT_W'(PORT_SLOTS - 1);
   assign map_idx  = q_dport - first_port_ff;
   assign map_ok   = {1'b0, map_idx} < 17'(PORT_SLOTS);
   assign free_idx = p_nport - first_port_ff;
   assign free_ok  = {1'b0, free_idx} < 17'(PORT_SLOTS);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      chk_in        = chk_ff;
      pend_in       = 1'b0;
      alloc_cnt_in  = alloc_cnt_ff;
      op_in         = op_ff;
      req_in        = req_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_age_in   = best_age_ff;
      best_order_in = best_order_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_wa        = cnt_ff[SLOT_W-1:0];
      mem_ra        = cnt_ff[SLOT_W-1:0];
      mem_wd        = '0;
      unique case (state_ff) inside
         S_INIT, S_CLR: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[SLOT_W-1:0] == SLOT_W'(PORT_SLOTS - 1)) begin
               state_in = S_IDLE;
               if (state_ff == S_CLR) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b0;
                  rsp_data_in  = '0;
               end
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in    = req_tuser;
               req_in   = req_tdata;
               cnt_in   = '0;
               found_in = 1'b0;
               case (req_tuser) inside
                  REQ_ALLOC, REQ_FIND: state_in = S_SCAN;
                  REQ_MAP:   state_in = S_MAP;
                  REQ_CLEAR: state_in = S_CLR;
                  default: begin
                     if (req_tuser == REQ_FREE && free_ok) begin
                        mem_we = 1'b1;
                        mem_wa = free_idx[SLOT_W-1:0];
                     end
                     rsp_valid_in = 1'b1;
                     rsp_hit_in   = 1'b0;
                     rsp_data_in  = '0;
                  end
               endcase
            end
         end
         S_MAP: begin
            mem_ra = map_idx[SLOT_W-1:0];
            if (!pend_ff) begin
               pend_in = 1'b1;
            end else begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = map_ok && rd_ff.valid;
               rsp_data_in  = (map_ok && rd_ff.valid) ?
                  {rd_ff.dport, rd_ff.dip, rd_ff.sport, rd_ff.sip, q_dport} : '0;
            end
         end
         S_SCAN: begin
            if (!cnt_ff[SLOT_W]) begin
               cnt_in  = cnt_ff + 1'b1;
               chk_in  = cnt_ff[SLOT_W-1:0];
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (op_ff == REQ_ALLOC) begin
                  if (in_lim && usable) begin
                     mem_we       = 1'b1;
                     mem_wa       = chk_ff;
                     mem_wd       = '{1'b1, q_sip, q_sport, q_dip, q_dport, q_now,
                                      alloc_cnt_ff};
                     alloc_cnt_in = alloc_cnt_ff + 1'b1;
                     state_in     = S_IDLE;
                     pend_in      = 1'b0;
                     rsp_valid_in = 1'b1;
                     rsp_hit_in   = 1'b1;
                     rsp_data_in  = {q_dport, q_dip, q_sport, q_sip, port_sum[15:0]};
                  end else if (!in_lim || last) begin
                     state_in     = S_IDLE;
                     pend_in      = 1'b0;
                     rsp_valid_in = 1'b1;
                     rsp_hit_in   = 1'b0;
                     rsp_data_in  = '0;
                  end
               end else begin
                  if (match && (!found_ff || age < best_age_ff)) begin
                     found_in      = 1'b1;
                     best_in       = chk_ff;
                     best_age_in   = age;
                     best_order_in = rd_ff.order;
                  end
                  if (last) begin
                     state_in = S_FWR;
                     pend_in  = 1'b0;
                  end
               end
            end
         end
         S_FWR: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_hit_in   = found_ff;
            rsp_data_in  = '0;
            if (found_ff) begin
               mem_we      = 1'b1;
               mem_wa      = best_ff;
               mem_wd      = '{1'b1, q_sip, q_sport, q_dip, q_dport, q_now, best_order_ff};
               rsp_data_in = {q_dport, q_dip, q_sport, q_sip,
                              16'(first_port_ff + 16'(best_ff))};
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         alloc_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         first_port_ff <= FIRST_PORT_RESET;
         timeout_ff    <= TIMEOUT_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         alloc_cnt_ff <= alloc_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_FIRST_PORT: first_port_ff <= csr_wdata[15:0];
               CSR_TIMEOUT:    timeout_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_ff        <= chk_in;
      op_ff         <= op_in;
      req_ff        <= req_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_age_ff   <= best_age_in;
      best_order_ff <= best_order_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_data_ff   <= rsp_data_in;
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rsp_valid_ff && state_ff == S_IDLE)
      else $error("request taken while busy");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> rsp_data_ff == '0)
      else $error("miss response carries data");
   a_one_write_alloc: assert property (@(posedge clock) disable iff (reset)
      (alloc_cnt_in != alloc_cnt_ff) |-> mem_we && state_ff == S_SCAN)
      else $error("allocation count moved without a write");
   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |=> !rsp_valid_ff)
      else $error("response during clearing pass");
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// self-checking testbench for the nat port table: allocate, find, map, free and clear requests
module tb_top;
   import npt_pkg::*;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] sip;
      logic [15:0] sport;
      logic [31:0] dip;
      logic [15:0] dport;
      logic [15:0] nport;
      logic [31:0] now;
   } request_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] nport;
      logic [31:0] sip;
      logic [15:0] sport;
      logic [31:0] dip;
      logic [15:0] dport;
   } mapping_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [143:0]  req_tdata;
   logic [2:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [111:0]  rsp_tdata;
   logic          rsp_tuser;
   logic          csr_we;
   logic          csr_addr;
   logic [31:0]   csr_wdata;

   nat_port_table_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // table copy
   logic          tbl_valid [PORT_SLOTS];
   logic [31:0]   tbl_sip   [PORT_SLOTS];
   logic [15:0]   tbl_sport [PORT_SLOTS];
   logic [31:0]   tbl_dip   [PORT_SLOTS];
   logic [15:0]   tbl_dport [PORT_SLOTS];
   logic [31:0]   tbl_stamp [PORT_SLOTS];
   logic [31:0]   tbl_order [PORT_SLOTS];
   logic [31:0]   alloc_count;
   logic [15:0]   base_port;
   logic [31:0]   idle_limit;

   request_type   pending_requests[$];
   mapping_type   expected_mappings[$];
   logic          req_taken;
   logic          calm;
   int            mismatches;
   int            stuck_cycles;

   // tuple pool and clock for the request generator
   logic [31:0]   pool_sip   [8];
   logic [15:0]   pool_sport [8];
   logic [31:0]   pool_dip   [8];
   logic [15:0]   pool_dport [8];
   logic [31:0]   wall_clock;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic mapping_type slot_mapping(int idx);
      mapping_type m;
      m.hit   = 1'b1;
      m.nport = base_port + idx[15:0];
      m.sip   = tbl_sip[idx];
      m.sport = tbl_sport[idx];
      m.dip   = tbl_dip[idx];
      m.dport = tbl_dport[idx];
      return m;
   endfunction

   function automatic mapping_type translate(request_type r);
      mapping_type m;
      int          lim;
      int          best;
      logic [31:0] best_age;
      logic [31:0] age;
      logic [15:0] idx;
      m = '0;
      case (r.kind)
         REQ_ALLOC: begin
            lim = 65536 - int'(base_port);
            if (lim > PORT_SLOTS) lim = PORT_SLOTS;
            for (int i = 0; i < lim; i++) begin
               if (tbl_valid[i] && (r.now - tbl_stamp[i]) <= idle_limit) continue;
               tbl_valid[i] = 1'b1;
               tbl_sip[i]   = r.sip;
               tbl_sport[i] = r.sport;
               tbl_dip[i]   = r.dip;
               tbl_dport[i] = r.dport;
               tbl_stamp[i] = r.now;
               tbl_order[i] = alloc_count;
               alloc_count  = alloc_count + 1;
               m = slot_mapping(i);
               break;
            end
         end
         REQ_FIND: begin
            best = -1;
            best_age = '0;
            for (int i = 0; i < PORT_SLOTS; i++) begin
               if (!tbl_valid[i] || tbl_sip[i] != r.sip || tbl_dip[i] != r.dip ||
                   tbl_sport[i] != r.sport || tbl_dport[i] != r.dport) continue;
               age = alloc_count - tbl_order[i];
               if (best < 0 || age < best_age) begin
                  best = i;
                  best_age = age;
               end
            end
            if (best >= 0) begin
               tbl_stamp[best] = r.now;
               m = slot_mapping(best);
            end
         end
         REQ_MAP: begin
            idx = r.dport - base_port;
            if (idx < PORT_SLOTS && tbl_valid[idx]) m = slot_mapping(idx);
         end
         REQ_FREE: begin
            idx = r.nport - base_port;
            if (idx < PORT_SLOTS) tbl_valid[idx] = 1'b0;
         end
         REQ_CLEAR: begin
            for (int i = 0; i < PORT_SLOTS; i++) tbl_valid[i] = 1'b0;
         end
         default: ;
      endcase
      return m;
   endfunction

   function automatic request_type pool_request(logic [2:0] kind, int p, logic [31:0] now);
      request_type r;
      r.kind  = kind;
      r.sip   = pool_sip[p];
      r.sport = pool_sport[p];
      r.dip   = pool_dip[p];
      r.dport = pool_dport[p];
      r.nport = 16'($urandom);
      r.now   = now;
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 8);
         if (!req_tvalid || req_taken) begin
            if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_requests[0].kind;
               req_tdata  <= {pending_requests[0].now, pending_requests[0].nport,
                              pending_requests[0].dport, pending_requests[0].dip,
                              pending_requests[0].sport, pending_requests[0].sip};
               void'(pending_requests.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      request_type r;
      mapping_type want;
      mapping_type got;
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready) begin
         r.kind  = req_tuser;
         r.sip   = req_tdata[31:0];
         r.sport = req_tdata[47:32];
         r.dip   = req_tdata[79:48];
         r.dport = req_tdata[95:80];
         r.nport = req_tdata[111:96];
         r.now   = req_tdata[143:112];
         expected_mappings.push_back(translate(r));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[15:0], rsp_tdata[47:16], rsp_tdata[63:48],
                rsp_tdata[95:64], rsp_tdata[111:96]};
         if (expected_mappings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = expected_mappings.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: hit %b/%b port %h/%h sip %h/%h sport %h/%h dip %h/%h dport %h/%h",
                           want.hit, got.hit, want.nport, got.nport, want.sip, got.sip,
                           want.sport, got.sport, want.dip, got.dip, want.dport, got.dport);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles > 30000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic write_csr(logic idx, logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      if (idx == CSR_FIRST_PORT) base_port = value[15:0];
      else idle_limit = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      while (pending_requests.size() > 0 || expected_mappings.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      request_type r;
      int          pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if ($urandom_range(9) == 0) wall_clock = $urandom;
         else wall_clock = wall_clock + $urandom_range(30);
         r = pool_request(REQ_ALLOC, $urandom_range(7), wall_clock);
         if (pick < 35) begin
            r.kind = REQ_ALLOC;
         end else if (pick < 62) begin
            r.kind = REQ_FIND;
         end else if (pick < 77) begin
            r.kind  = REQ_MAP;
            r.dport = ($urandom_range(3) == 0) ? 16'($urandom)
                                               : 16'(base_port + $urandom_range(12));
         end else if (pick < 89) begin
            r.kind  = REQ_FREE;
            r.nport = ($urandom_range(3) == 0) ? 16'($urandom)
                                               : 16'(base_port + $urandom_range(12));
         end else if (pick < 91) begin
            r.kind = REQ_CLEAR;
         end else if (pick < 95) begin
            r.kind = 3'($urandom_range(5, 7));
         end else begin
            r = request_type'({$urandom, $urandom, $urandom, $urandom, 19'($urandom)});
            r.kind = ($urandom_range(1)) ? REQ_ALLOC : REQ_FIND;
         end
         pending_requests.push_back(r);
      end
      drain();
   endtask

   initial begin
      request_type r;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = 1'b0;
      csr_wdata  = '0;
      req_taken  = 1'b0;
      calm       = 1'b0;
      mismatches = 0;
      stuck_cycles = 0;
      for (int i = 0; i < PORT_SLOTS; i++) tbl_valid[i] = 1'b0;
      alloc_count = '0;
      base_port   = FIRST_PORT_RESET;
      idle_limit  = TIMEOUT_RESET;
      for (int p = 0; p < 8; p++) begin
         pool_sip[p]   = $urandom;
         pool_sport[p] = 16'($urandom);
         pool_dip[p]   = $urandom;
         pool_dport[p] = 16'($urandom);
      end
      pool_sip[0] = '0; pool_sport[0] = '0; pool_dip[0] = '0; pool_dport[0] = '0;
      pool_sip[1] = '1; pool_sport[1] = '1; pool_dip[1] = '1; pool_dport[1] = '1;
      wall_clock = 100;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults, reuse after timeout, backwards time, newest match
      pending_requests.push_back(pool_request(REQ_FIND, 0, 0));
      pending_requests.push_back(pool_request(REQ_ALLOC, 0, 0));
      pending_requests.push_back(pool_request(REQ_ALLOC, 1, 32'hFFFF_FFFF));
      pending_requests.push_back(pool_request(REQ_ALLOC, 0, 10));
      pending_requests.push_back(pool_request(REQ_FIND, 0, 20));
      pending_requests.push_back(pool_request(REQ_FIND, 1, 30));
      pending_requests.push_back(pool_request(REQ_FIND, 2, 30));
      pending_requests.push_back(pool_request(REQ_ALLOC, 2, 81));
      pending_requests.push_back(pool_request(REQ_ALLOC, 3, 5));
      r = pool_request(REQ_MAP, 0, 0);
      r.dport = 16'd10000;
      pending_requests.push_back(r);
      r.dport = 16'd10002;
      pending_requests.push_back(r);
      r.dport = 16'd9999;
      pending_requests.push_back(r);
      r.dport = 16'hFFFF;
      pending_requests.push_back(r);
      r.kind = REQ_FREE;
      r.nport = 16'd10001;
      pending_requests.push_back(r);
      r.nport = 16'd10001;
      pending_requests.push_back(r);
      r.nport = 16'd0;
      pending_requests.push_back(r);
      pending_requests.push_back(pool_request(3'd5, 4, 1));
      pending_requests.push_back(pool_request(3'd6, 5, 1));
      pending_requests.push_back(pool_request(3'd7, 6, 1));
      pending_requests.push_back(pool_request(REQ_CLEAR, 6, 1));
      pending_requests.push_back(pool_request(REQ_FIND, 1, 1));
      pending_requests.push_back(pool_request(REQ_ALLOC, 4, 2));
      drain();
      random_phase(30);

      // top of the port range, only a handful of slots
      write_csr(CSR_FIRST_PORT, 32'd65530);
      write_csr(CSR_TIMEOUT, 32'd0);
      calm = 1'b1;
      random_phase(30);
      calm = 1'b0;

      write_csr(CSR_FIRST_PORT, 32'd0);
      write_csr(CSR_TIMEOUT, 32'hFFFF_FFFF);
      random_phase(30);

      write_csr(CSR_FIRST_PORT, 32'd61440);
      write_csr(CSR_TIMEOUT, 32'd5);
      random_phase(30);

      if (mismatches == 0 && expected_mappings.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// File: filelist.f
hw/rtl/npt_pkg.sv
hw/rtl/nat_port_table_top.sv
tb/sv/tb_top.sv
